### hw/rtl/asgr_pkg.sv
// Shared types and constants of the ANSI SGR escape sequence parser.
package asgr_pkg;

    // Width of the internal byte position counter; positions wrap at this width.
    localparam int POS_WIDTH = 32;
    // Width of the position fields on the result channel.
    localparam int OUT_POS_WIDTH = 32;

    typedef logic [POS_WIDTH-1:0] t_pos;
    localparam t_pos POS_ZERO = t_pos'(0);
    localparam t_pos POS_ONE = t_pos'(1);

    // Character codes the parser reacts to.
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_M = 8'h6D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Default colour index for foreground and background.
    localparam logic [4:0] COLOUR_DEFAULT = 5'd16;

    // Bit positions of the attributes in the attribute flags.
    localparam int ATTR_BOLD = 0;
    localparam int ATTR_FAINT = 1;
    localparam int ATTR_ITALIC = 2;
    localparam int ATTR_UNDERLINE = 3;
    localparam int ATTR_BLINK = 4;
    localparam int ATTR_INVERSE = 5;
    localparam int ATTR_CONCEAL = 6;
    localparam int ATTR_STRIKE = 7;

    // Current text style.
    typedef struct packed {
        logic [7:0] attr;
        logic [4:0] fore;
        logic [4:0] back;
    } t_style;

    localparam t_style STYLE_RESET = '{attr: 8'h00, fore: COLOUR_DEFAULT,
                                       back: COLOUR_DEFAULT};

    // Parser state carried from one byte to the next.
    typedef struct packed {
        logic       in_seq;
        logic [7:0] param_accum;
        logic       have_digit;
        t_pos       pos;
        t_pos       seq_start;
        t_style     style;
    } t_parse_state;

    // One decoded escape sequence, plus the flag that says one was produced.
    typedef struct packed {
        logic   emit;
        t_pos   start_pos;
        t_pos   end_pos;
        t_style style;
    } t_result;

endpackage

### hw/rtl/asgr_intf.sv
// Handshake channels of the parser: the byte request stream and the result stream.
interface asgr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface asgr_sgr_if;
    logic                               valid;
    logic                               ready;
    logic [asgr_pkg::OUT_POS_WIDTH-1:0] start_pos;
    logic [asgr_pkg::OUT_POS_WIDTH-1:0] end_pos;
    logic                               bold;
    logic                               faint;
    logic                               italic;
    logic                               underline;
    logic                               blink;
    logic                               inverse;
    logic                               conceal;
    logic                               strike;
    logic [4:0]                         fore_colour;
    logic [4:0]                         back_colour;

    modport source (
        output valid, output start_pos, output end_pos,
        output bold, output faint, output italic, output underline,
        output blink, output inverse, output conceal, output strike,
        output fore_colour, output back_colour,
        input ready
    );
    modport sink (
        input valid, input start_pos, input end_pos,
        input bold, input faint, input italic, input underline,
        input blink, input inverse, input conceal, input strike,
        input fore_colour, input back_colour,
        output ready
    );
endinterface

### hw/rtl/asgr_step.sv
// Per-byte decode logic: next parser state and the optional result for one byte.
module asgr_step (
    input  asgr_pkg::t_parse_state i_state,
    input  logic [7:0]             i_byte_value,
    input  logic                   i_last_byte,
    output asgr_pkg::t_parse_state o_state,
    output asgr_pkg::t_result      o_result
);

    localparam logic [11:0] PARAM_MAX = 12'd255;

    // Attribute bit that an SGR set code from 1 to 9 turns on.
    function automatic logic [2:0] set_bit(input logic [7:0] code);
        logic [2:0] b;
        case (code) inside
            [8'd1:8'd4]: b = 3'(code - 8'd1);
            8'd5, 8'd6:  b = 3'(asgr_pkg::ATTR_BLINK);
            [8'd7:8'd9]: b = 3'(code - 8'd2);
            default:     b = 3'd0;
        endcase
        return b;
    endfunction

    // Apply one SGR code to a style.
    function automatic asgr_pkg::t_style apply_code(input asgr_pkg::t_style s,
                                                    input logic [7:0] code);
        asgr_pkg::t_style r;
        r = s;
        case (code) inside
            8'd0:              r = asgr_pkg::STYLE_RESET;
            [8'd1:8'd9]:       r.attr[set_bit(code)] = 1'b1;
            8'd21, 8'd22: begin
                r.attr[asgr_pkg::ATTR_BOLD] = 1'b0;
                r.attr[asgr_pkg::ATTR_FAINT] = 1'b0;
            end
            8'd23:             r.attr[asgr_pkg::ATTR_ITALIC] = 1'b0;
            8'd24:             r.attr[asgr_pkg::ATTR_UNDERLINE] = 1'b0;
            8'd25:             r.attr[asgr_pkg::ATTR_BLINK] = 1'b0;
            8'd27:             r.attr[asgr_pkg::ATTR_INVERSE] = 1'b0;
            8'd29:             r.attr[asgr_pkg::ATTR_STRIKE] = 1'b0;
            [8'd30:8'd37]:     r.fore = 5'(code - 8'd30);
            [8'd90:8'd97]:     r.fore = 5'(code - 8'd82);
            [8'd40:8'd47]:     r.back = 5'(code - 8'd40);
            [8'd100:8'd107]:   r.back = 5'(code - 8'd92);
            default:           r = s;
        endcase
        return r;
    endfunction

    asgr_pkg::t_parse_state s1;
    asgr_pkg::t_pos         pos_next;
    logic [11:0]            digit_sum;
    logic                   emit_m;
    logic                   emit_last;

    assign pos_next = i_state.pos + asgr_pkg::POS_ONE;
    assign digit_sum = 12'(i_state.param_accum) * 12'd10
                     + 12'(i_byte_value - asgr_pkg::CH_ZERO);

    // First pass: effect of the byte itself.
    always_comb begin
        s1 = i_state;
        emit_m = 1'b0;
        if (i_byte_value == asgr_pkg::CH_ESC) begin
            s1.in_seq = 1'b1;
            s1.seq_start = i_state.pos;
            s1.param_accum = 8'd0;
            s1.have_digit = 1'b0;
            s1.style = asgr_pkg::STYLE_RESET;
        end else if (i_state.in_seq) begin
            case (i_byte_value) inside
                [asgr_pkg::CH_ZERO:asgr_pkg::CH_NINE]: begin
                    s1.param_accum = (digit_sum > PARAM_MAX) ? 8'hFF : digit_sum[7:0];
                    s1.have_digit = 1'b1;
                end
                asgr_pkg::CH_SEMI, asgr_pkg::CH_M: begin
                    s1.style = apply_code(i_state.style,
                                          i_state.have_digit ? i_state.param_accum : 8'd0);
                    s1.param_accum = 8'd0;
                    s1.have_digit = 1'b0;
                    if (i_byte_value == asgr_pkg::CH_M) begin
                        s1.in_seq = 1'b0;
                        emit_m = 1'b1;
                    end
                end
                default: s1 = i_state;
            endcase
        end
    end

    // Second pass: a last byte closes any sequence still open.
    always_comb begin
        o_state = s1;
        emit_last = i_last_byte && s1.in_seq;
        if (emit_last) begin
            o_state.style = apply_code(s1.style, s1.have_digit ? s1.param_accum : 8'd0);
        end
        if (i_last_byte) begin
            o_state.in_seq = 1'b0;
            o_state.param_accum = 8'd0;
            o_state.have_digit = 1'b0;
            o_state.pos = asgr_pkg::POS_ZERO;
        end else begin
            o_state.pos = pos_next;
        end
    end

    // Result fields, taken from the state after this byte.
    always_comb begin
        o_result.emit = emit_m || emit_last;
        o_result.start_pos = s1.seq_start;
        o_result.end_pos = pos_next;
        o_result.style = o_state.style;
    end

endmodule

### hw/rtl/ansi_sgr_escape_parser.sv
// Top level of the ANSI SGR escape sequence parser: input, state and result registers.
// The parser takes one text byte per cycle while the result channel is ready and reports
// each SGR escape sequence once it ends with 'm' or is cut off by the last byte of the
// text. A byte accepted on the input channel is held in an input register until the
// decode stage moves, and its result (if any) is then registered in the output register.
// The sustained rate is one byte per clock cycle while the result channel is ready; it
// is set by the state update of the decode stage, and a stalled result only holds the
// input stage once a byte waits behind it. Positions count bytes from the start of the
// current text and start again at zero after a byte marked last; they wrap at
// asgr_pkg::POS_WIDTH bits and the result fields carry the low bits.
module ansi_sgr_escape_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    asgr_byte_if.sink   i_byte,
    asgr_sgr_if.source  o_sgr
);

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_last;
    asgr_pkg::t_parse_state r_state;
    asgr_pkg::t_parse_state n_state;
    asgr_pkg::t_result      n_result;
    logic                   r_out_valid;
    asgr_pkg::t_result      r_out;
    logic                   advance;
    logic                   out_take;

    // The decode stage moves when the result register is free or being emptied.
    assign out_take = r_out_valid && o_sgr.ready;
    assign advance = r_in_valid && (!r_out_valid || o_sgr.ready);
    assign i_byte.ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.byte_value;
            r_in_last <= i_byte.last_byte;
        end
    end

    // Per-byte decode.
    asgr_step u_step (
        .i_state      (r_state),
        .i_byte_value (r_in_byte),
        .i_last_byte  (r_in_last),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{in_seq: 1'b0, param_accum: 8'd0, have_digit: 1'b0,
                         pos: asgr_pkg::POS_ZERO, seq_start: asgr_pkg::POS_ZERO,
                         style: asgr_pkg::STYLE_RESET};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && n_result.emit) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_result.emit) begin
            r_out <= n_result;
        end
    end

    // Result channel.
    assign o_sgr.valid = r_out_valid;
    assign o_sgr.start_pos = asgr_pkg::OUT_POS_WIDTH'(r_out.start_pos);
    assign o_sgr.end_pos = asgr_pkg::OUT_POS_WIDTH'(r_out.end_pos);
    assign o_sgr.bold = r_out.style.attr[asgr_pkg::ATTR_BOLD];
    assign o_sgr.faint = r_out.style.attr[asgr_pkg::ATTR_FAINT];
    assign o_sgr.italic = r_out.style.attr[asgr_pkg::ATTR_ITALIC];
    assign o_sgr.underline = r_out.style.attr[asgr_pkg::ATTR_UNDERLINE];
    assign o_sgr.blink = r_out.style.attr[asgr_pkg::ATTR_BLINK];
    assign o_sgr.inverse = r_out.style.attr[asgr_pkg::ATTR_INVERSE];
    assign o_sgr.conceal = r_out.style.attr[asgr_pkg::ATTR_CONCEAL];
    assign o_sgr.strike = r_out.style.attr[asgr_pkg::ATTR_STRIKE];
    assign o_sgr.fore_colour = r_out.style.fore;
    assign o_sgr.back_colour = r_out.style.back;

`ifndef ASSERT_OFF
    // A held byte keeps its value while the decode stage waits.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
        else $error("held input byte changed while stalled");

    // A byte marked last starts the next text at position zero.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_state.pos == asgr_pkg::POS_ZERO && !r_state.in_seq)
        else $error("position not cleared after last byte");

    // Every reported sequence closes the open sequence.
    a_emit_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_result.emit |=> !r_state.in_seq)
        else $error("sequence still open after its result");

    // A new result only appears when the decode stage moved.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance))
        else $error("result appeared without a decoded byte");
`endif

endmodule
